// ===== hw/rtl/asymmetric_damped_spring_follower_top_assert.svh =====
// Assertion macros for the spring follower.
// Both macros sample on clk and are held off while rst_n is low.
`ifndef ASYMMETRIC_DAMPED_SPRING_FOLLOWER_TOP_ASSERT_SVH
`define ASYMMETRIC_DAMPED_SPRING_FOLLOWER_TOP_ASSERT_SVH

// Same-cycle implication.
`define ASDSF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spring follower check failed");

// Next-cycle implication.
`define ASDSF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spring follower check failed");

`endif

// ===== hw/rtl/asdsf_pkg.sv =====
package asdsf_pkg;

    localparam int DATA_W  = 32;
    localparam int TIME_W  = 21;
    localparam int K_W     = 24;
    localparam int D_W     = 17;
    localparam int DB_W    = 31;
    localparam int CFG_W   = 3;

    // Shared multiplier: signed 32 x signed 25 (gains and dt are zero-extended)
    localparam int MUL_A_W = DATA_W;
    localparam int MUL_B_W = K_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int Q_FRAC  = 16;
    localparam int T_FRAC  = 20;

    localparam int STEPS_PER_SECOND_DEF = 100;
    localparam int ONE_SECOND_INT       = 1 << T_FRAC;
    localparam logic [TIME_W-1:0] ONE_SECOND_Q20 = TIME_W'(ONE_SECOND_INT);

    localparam logic [K_W-1:0]  STIFF_RST = K_W'(65536);
    localparam logic [D_W-1:0]  DAMP_RST  = D_W'(65536);
    localparam logic [DB_W-1:0] DB_RST    = '0;

    typedef enum logic [CFG_W-1:0] {
        CFG_STIFF_POS = 3'd0,
        CFG_STIFF_NEG = 3'd1,
        CFG_DAMP_POS  = 3'd2,
        CFG_DAMP_NEG  = 3'd3,
        CFG_DEAD_BAND = 3'd4
    } cfg_idx_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end
        else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/asymmetric_damped_spring_follower_top.sv =====
// Asymmetric damped spring follower. Each input word carries an elapsed time
// (Q0.20 s, clipped to 1 s), a target position and an optional external force
// (Q16.16); the block advances its internal position and velocity by fixed
// substeps of 1/STEPS_PER_SECOND s plus one final substep for the remainder
// (possibly zero), and returns one output word with the new position and
// velocity (both Q16.16, saturated). Per substep: force is the external force
// or target minus position, forced to zero inside the dead band, scaled by the
// positive or negative stiffness; velocity takes force*dt and is then scaled
// by the damping for its sign; position adds velocity. All three products run
// through one shared 32x25 multiplier; each substep walks the states FORCE,
// MULK, MULDT, VEL, MULD and POS, and after the last one STORE loads the output
// register and the sequencer returns to idle. With the default 100 steps per
// second there are at most 101 substeps. A held output register stalls the
// final store until it frees up.
// s_tready is high only while the sequencer is idle; a finished
// result waits in the output register, so the next word can be accepted while
// it is pending. Configuration writes are taken at any time (cfg_ready is tied
// high) but must only be issued while no item is in flight. Position and
// velocity reset to zero, gains to 1.0, dead band to zero.
`include "asymmetric_damped_spring_follower_top_assert.svh"

module asymmetric_damped_spring_follower_top #(
    parameter int STEPS_PER_SECOND = asdsf_pkg::STEPS_PER_SECOND_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [87:0]                        s_tdata,   // elapsed_time[20:0],
                                                          // target_position[52:21],
                                                          // external_force[84:53], pad
    input  logic                               s_tuser,   // use_external_force
    // output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [63:0]                        m_tdata,   // position[31:0], velocity[63:32]
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [asdsf_pkg::CFG_W-1:0]        cfg_index,
    input  logic [asdsf_pkg::DB_W-1:0]         cfg_data
);
    import asdsf_pkg::*;

    // substep length in Q0.20
    localparam logic [TIME_W-1:0] INTERVAL = TIME_W'(ONE_SECOND_INT / STEPS_PER_SECOND);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_FORCE = 8'b0000_0010,
        ST_MULK  = 8'b0000_0100,
        ST_MULDT = 8'b0000_1000,
        ST_VEL   = 8'b0001_0000,
        ST_MULD  = 8'b0010_0000,
        ST_POS   = 8'b0100_0000,
        ST_STORE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [K_W-1:0]  stiff_pos_reg, stiff_neg_reg;
    logic [D_W-1:0]  damp_pos_reg, damp_neg_reg;
    logic [DB_W-1:0] dead_band_reg;

    // spring state
    logic signed [DATA_W-1:0] pos_reg, vel_reg;

    // per-item payload
    logic [TIME_W-1:0]        t_reg;
    logic signed [DATA_W-1:0] tgt_reg, ext_reg;
    logic                     use_ext_reg;

    // per-substep working registers
    logic [TIME_W-1:0]        dt_reg;
    logic                     last_reg;
    logic signed [DATA_W-1:0] force_reg;
    logic [K_W-1:0]           k_reg;
    logic signed [DATA_W-1:0] vel_sum_reg;

    // output register
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;

    // shared multiplier
    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic                      in_accept;
    logic                      out_free;

    logic signed [DATA_W:0]    diff;
    logic signed [DATA_W-1:0]  f_sel;
    logic signed [DATA_W:0]    f_ext, db_pos, db_neg;
    logic                      in_band;
    logic signed [DATA_W-1:0]  f_dead;

    logic signed [DATA_W-1:0]  scaled;
    logic signed [DATA_W-1:0]  vel_sum;
    logic signed [DATA_W-1:0]  vel_new;
    logic signed [DATA_W-1:0]  pos_new;
    logic [D_W-1:0]            damp_sel;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiff_pos_reg <= STIFF_RST;
            stiff_neg_reg <= STIFF_RST;
            damp_pos_reg  <= DAMP_RST;
            damp_neg_reg  <= DAMP_RST;
            dead_band_reg <= DB_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_STIFF_POS: stiff_pos_reg <= cfg_data[K_W-1:0];
                CFG_STIFF_NEG: stiff_neg_reg <= cfg_data[K_W-1:0];
                CFG_DAMP_POS:  damp_pos_reg  <= cfg_data[D_W-1:0];
                CFG_DAMP_NEG:  damp_neg_reg  <= cfg_data[D_W-1:0];
                CFG_DEAD_BAND: dead_band_reg <= cfg_data;
                default:       ;   // unknown index: ignored
            endcase
        end
    end

    // ---------------- force select and dead band ----------------
    assign diff   = (DATA_W+1)'(tgt_reg) - (DATA_W+1)'(pos_reg);
    assign f_sel  = use_ext_reg ? ext_reg : sat32(64'(diff));
    assign f_ext  = (DATA_W+1)'(f_sel);
    assign db_pos = signed'({2'b00, dead_band_reg});
    assign db_neg = -db_pos;
    // |f| < dead_band without forming |f|
    assign in_band = f_sel[DATA_W-1] ? (f_ext > db_neg) : (f_ext < db_pos);
    assign f_dead  = in_band ? '0 : f_sel;

    // ---------------- datapath after the multiplier ----------------
    assign scaled   = sat32(64'(prod >>> Q_FRAC));
    assign vel_sum  = sat32(64'(vel_reg) + 64'(prod >>> T_FRAC));
    assign vel_new  = sat32(64'(prod >>> Q_FRAC));
    assign pos_new  = sat32(64'(pos_reg) + 64'(vel_new));
    assign damp_sel = vel_sum_reg[DATA_W-1] ? damp_neg_reg : damp_pos_reg;

    // multiplier operand select
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            ST_MULK:
            begin
                mul_en = 1'b1;
                mul_a  = force_reg;
                mul_b  = signed'({1'b0, k_reg});
            end
            ST_MULDT:
            begin
                mul_en = 1'b1;
                mul_a  = scaled;
                mul_b  = signed'({{(MUL_B_W-TIME_W){1'b0}}, dt_reg});
            end
            ST_MULD:
            begin
                mul_en = 1'b1;
                mul_a  = vel_sum_reg;
                mul_b  = signed'({{(MUL_B_W-D_W){1'b0}}, damp_sel});
            end
            default: ;
        endcase
    end

    asdsf_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_accept) state_next = ST_FORCE;
            ST_FORCE: state_next = ST_MULK;
            ST_MULK:  state_next = ST_MULDT;
            ST_MULDT: state_next = ST_VEL;
            ST_VEL:   state_next = ST_MULD;
            ST_MULD:  state_next = ST_POS;
            ST_POS:   state_next = last_reg ? ST_STORE : ST_FORCE;
            ST_STORE: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            vel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_POS)
            begin
                vel_reg <= vel_new;
                pos_reg <= pos_new;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            t_reg       <= (s_tdata[20:0] > ONE_SECOND_Q20) ? ONE_SECOND_Q20 : s_tdata[20:0];
            tgt_reg     <= s_tdata[52:21];
            ext_reg     <= s_tdata[84:53];
            use_ext_reg <= s_tuser;
        end
        if (state_reg == ST_FORCE)
        begin
            // full substep while more than one interval remains
            if ((INTERVAL != '0) && (t_reg > INTERVAL))
            begin
                dt_reg   <= INTERVAL;
                t_reg    <= t_reg - INTERVAL;
                last_reg <= 1'b0;
            end
            else
            begin
                dt_reg   <= t_reg;
                last_reg <= 1'b1;
            end
            force_reg <= f_dead;
            k_reg     <= f_dead[DATA_W-1] ? stiff_neg_reg : stiff_pos_reg;
        end
        if (state_reg == ST_VEL)
        begin
            vel_sum_reg <= vel_sum;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (state_reg == ST_STORE && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_STORE && out_free)
        begin
            m_tdata_reg <= {vel_reg, pos_reg};
        end
    end

    // ---------------- assertions ----------------
    `ASDSF_ASSERT_NXT(a_accept_starts, in_accept, state_reg == ST_FORCE)
    `ASDSF_ASSERT_IMP(a_valid_from_store, $rose(m_tvalid), $past(state_reg == ST_STORE))
    `ASDSF_ASSERT_IMP(a_time_clipped, state_reg == ST_FORCE, t_reg <= ONE_SECOND_Q20)

endmodule

// ===== hw/rtl/asdsf_mul.sv =====
module asdsf_mul (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [asdsf_pkg::MUL_A_W-1:0]  a,
    input  logic signed [asdsf_pkg::MUL_B_W-1:0]  b,
    output logic signed [asdsf_pkg::PROD_W-1:0]   prod
);
    import asdsf_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    // registered product, held until the next enable
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(a) * PROD_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule

// ===== dv/tb.sv =====
module tb;
    import asdsf_pkg::*;

    // Substep length in Q0.20, as the block derives it from its default rate.
    localparam int SUBSTEP_Q20  = ONE_SECOND_INT / STEPS_PER_SECOND_DEF;
    // Covers the longest item, 101 substeps plus overhead, with margin.
    localparam int DRAIN_CYCLES = 6 * (STEPS_PER_SECOND_DEF + 1) + 64;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 125;

    typedef struct {
        logic [TIME_W-1:0]        elapsed;
        logic signed [DATA_W-1:0] target;
        logic                     ext_on;
        logic signed [DATA_W-1:0] ext_force;
    } step_t;

    typedef struct {
        logic signed [DATA_W-1:0] position;
        logic signed [DATA_W-1:0] velocity;
    } spring_state_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [87:0]       s_tdata   = '0;
    logic              s_tuser   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [63:0]       m_tdata;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_index = '0;
    logic [DB_W-1:0]   cfg_data  = '0;

    // Shadow copy of the block's registers and spring state.
    logic [K_W-1:0]           k_pos_m = STIFF_RST;
    logic [K_W-1:0]           k_neg_m = STIFF_RST;
    logic [D_W-1:0]           d_pos_m = DAMP_RST;
    logic [D_W-1:0]           d_neg_m = DAMP_RST;
    logic [DB_W-1:0]          band_m  = DB_RST;
    logic signed [DATA_W-1:0] pos_m   = '0;
    logic signed [DATA_W-1:0] vel_m   = '0;

    spring_state_t pending_states[$];
    int            error_count = 0;
    int            burst_left  = 0;
    logic [9:0]    stall_tick  = '0;

    asymmetric_damped_spring_follower_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Spring predictor
    // ------------------------------------------------------------------
    function automatic logic signed [DATA_W-1:0] clip32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[DATA_W-1:0];
    endfunction

    // One Euler substep; >>> on signed 64-bit rounds toward minus infinity.
    function automatic void spring_substep(input longint dt, input longint pull);
        longint f, thr, gain, scaled, v, damp, p;
        f   = pull;
        thr = band_m;
        // only a magnitude strictly below the band is zeroed
        if (((f < 0) ? -f : f) < thr)
        begin
            f = 0;
        end
        gain   = (f < 0) ? k_neg_m : k_pos_m;
        scaled = clip32((f * gain) >>> Q_FRAC);
        v      = clip32(vel_m + ((scaled * dt) >>> T_FRAC));
        damp   = (v < 0) ? d_neg_m : d_pos_m;
        vel_m  = clip32((v * damp) >>> Q_FRAC);
        p      = pos_m;
        pos_m  = clip32(p + longint'(vel_m));
    endfunction

    function automatic longint pull_of(input step_t it);
        longint tgt, p;
        if (it.ext_on)
        begin
            return it.ext_force;
        end
        tgt = it.target;
        p   = pos_m;
        return clip32(tgt - p);
    endfunction

    function automatic spring_state_t predict_spring(input step_t it);
        longint        remaining;
        spring_state_t r;
        remaining = it.elapsed;
        if (remaining > ONE_SECOND_INT)
        begin
            remaining = ONE_SECOND_INT;
        end
        while (remaining > SUBSTEP_Q20)
        begin
            spring_substep(SUBSTEP_Q20, pull_of(it));
            remaining -= SUBSTEP_Q20;
        end
        // last substep takes the remainder, zero included
        spring_substep(remaining, pull_of(it));
        r.position = pos_m;
        r.velocity = vel_m;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic step_t step_of(input int t, input logic signed [DATA_W-1:0] tgt,
                                      input logic ext_on,
                                      input logic signed [DATA_W-1:0] ext_force);
        step_t it;
        it.elapsed   = t[TIME_W-1:0];
        it.target    = tgt;
        it.ext_on    = ext_on;
        it.ext_force = ext_force;
        return it;
    endfunction

    // Sends one word. Valid is left high on return so back-to-back words in a
    // burst never see valid dropped and raised in the same step.
    task automatic push_step(input step_t it);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, it.ext_force, it.target, it.elapsed};
        s_tuser  <= it.ext_on;
        // inputs only move at posedge, so negedge sees the settled handshake
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        @(posedge clk);
        pending_states.push_back(predict_spring(it));
    endtask

    // Block is idle once the last word is out; registers may be written then.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_states.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input logic [DB_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx[CFG_W-1:0];
        cfg_data  <= value;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        @(posedge clk);
        case (idx)
            CFG_STIFF_POS: k_pos_m = value[K_W-1:0];
            CFG_STIFF_NEG: k_neg_m = value[K_W-1:0];
            CFG_DAMP_POS:  d_pos_m = value[D_W-1:0];
            CFG_DAMP_NEG:  d_neg_m = value[D_W-1:0];
            CFG_DEAD_BAND: band_m  = value;
            default: ;  // unused index, write dropped
        endcase
    endtask

    task automatic load_gains(input logic [DB_W-1:0] kp, input logic [DB_W-1:0] kn,
                              input logic [DB_W-1:0] dp, input logic [DB_W-1:0] dn,
                              input logic [DB_W-1:0] db);
        wait_idle();
        write_reg(CFG_STIFF_POS, kp);
        write_reg(CFG_STIFF_NEG, kn);
        write_reg(CFG_DAMP_POS, dp);
        write_reg(CFG_DAMP_NEG, dn);
        write_reg(CFG_DEAD_BAND, db);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern cycles through four modes, set by stall_tick[9:8]:
    // always ready, coin flip, one cycle in eight, mostly ready.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1'b1;
        case (stall_tick[9:8])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= 1'($urandom_range(0, 1));
            2'd2:    m_tready <= (stall_tick[2:0] == 3'd0);
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Result check: a handshake seen at negedge completes at the next posedge.
    always @(negedge clk)
    begin : check_result
        spring_state_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_states.size() == 0)
            begin
                $error("unexpected output word: position %0d velocity %0d",
                       $signed(m_tdata[31:0]), $signed(m_tdata[63:32]));
                error_count++;
            end
            else
            begin
                want = pending_states.pop_front();
                if (m_tdata[31:0] !== want.position)
                begin
                    $error("position: expected %0d, got %0d",
                           want.position, $signed(m_tdata[31:0]));
                    error_count++;
                end
                if (m_tdata[63:32] !== want.velocity)
                begin
                    $error("velocity: expected %0d, got %0d",
                           want.velocity, $signed(m_tdata[63:32]));
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset gains; zero time, one tick, exactly one substep, one past it,
    // a full second, and times above a second that must clip.
    task automatic test_time_edges();
        push_step(step_of(0, 32'sh0001_0000, 1'b0, '0));
        push_step(step_of(1, 32'sh0001_0000, 1'b0, '0));
        push_step(step_of(SUBSTEP_Q20, 32'sh0002_0000, 1'b0, '0));
        push_step(step_of(SUBSTEP_Q20 + 1, 32'sh0002_0000, 1'b0, '0));
        push_step(step_of(ONE_SECOND_INT, -32'sh0005_0000, 1'b0, '0));
        push_step(step_of((1 << TIME_W) - 1, 32'sh7FFF_FFFF, 1'b0, 32'sh7FFF_FFFF));
        push_step(step_of(ONE_SECOND_INT + 1, 32'sh8000_0000, 1'b1, 32'sh8000_0000));
    endtask

    // Largest gains and damping above unity drive both outputs into
    // saturation; zero gains zero the velocity and hold position; damping split by sign.
    task automatic test_saturation();
        load_gains(31'hFF_FFFF, 31'hFF_FFFF, 31'h1_FFFF, 31'h1_FFFF, '0);
        push_step(step_of(ONE_SECOND_INT, '0, 1'b1, 32'sh7FFF_FFFF));
        push_step(step_of(ONE_SECOND_INT, '0, 1'b1, 32'sh8000_0000));
        load_gains('0, '0, '0, '0, '0);
        push_step(step_of(3 * SUBSTEP_Q20, '0, 1'b0, '0));
        load_gains(31'h1_0000, 31'h1_0000, '0, 31'h1_0000, '0);
        push_step(step_of(2 * SUBSTEP_Q20, '0, 1'b1, 32'sh0004_0000));
        push_step(step_of(2 * SUBSTEP_Q20, '0, 1'b1, -32'sh0004_0000));
    endtask

    // Force equal to the band passes, one below is zeroed; a zeroed negative
    // force must use the positive stiffness (gains are asymmetric here).
    task automatic test_dead_band();
        load_gains(31'h2_0000, 31'h0_8000, 31'h0_F000, 31'h0_F000, 31'h1_0000);
        push_step(step_of(20000, '0, 1'b1, 32'sh0001_0000));
        push_step(step_of(20000, '0, 1'b1, 32'sh0000_FFFF));
        push_step(step_of(20000, '0, 1'b1, -32'sh0001_0000));
        push_step(step_of(20000, '0, 1'b1, -32'sh0000_FFFF));
        load_gains(31'h2_0000, 31'h0_8000, 31'h0_F000, 31'h0_F000, 31'h7FFF_FFFF);
        push_step(step_of(20000, '0, 1'b1, 32'sh7FFF_FFFF));
        push_step(step_of(20000, '0, 1'b1, 32'sh8000_0000));
        push_step(step_of(20000, '0, 1'b1, 32'sh7FFF_FFFE));
        push_step(step_of(20000, 32'sh4000_0000, 1'b0, '0));
    endtask

    // Writes to indexes past the last register must leave every gain alone.
    task automatic test_unused_index();
        load_gains(31'h1_8000, 31'h0_6000, 31'h0_FA00, 31'h0_F000, 31'h0_0200);
        for (int i = int'(CFG_DEAD_BAND) + 1; i < (1 << CFG_W); i++)
        begin
            write_reg(i, 31'($urandom));
        end
        cfg_valid <= 1'b0;
        push_step(step_of(16667, 32'sh0003_0000, 1'b0, '0));
        push_step(step_of(16667, '0, 1'b1, -32'sh0002_0000));
    endtask

    function automatic step_t random_step();
        step_t it;
        int    sel;
        sel = $urandom_range(0, 19);
        if (sel < 11)
        begin
            it.elapsed = TIME_W'($urandom_range(0, 40000));
        end
        else if (sel < 14)
        begin
            it.elapsed = TIME_W'($urandom_range(0, SUBSTEP_Q20 + 2));
        end
        else if (sel < 17)
        begin
            it.elapsed = TIME_W'($urandom_range(0, ONE_SECOND_INT));
        end
        else
        begin
            it.elapsed = TIME_W'($urandom);
        end
        if ($urandom_range(0, 4) == 0)
        begin
            it.target = $urandom;
        end
        else
        begin
            it.target = 32'($urandom_range(0, 32'h03FF_FFFF) - 32'h0200_0000);
        end
        it.ext_on = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 1) == 0)
        begin
            it.ext_force = $urandom;
        end
        else
        begin
            it.ext_force = 32'($urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000);
        end
        return it;
    endfunction

    // Phases of random words under changing gains: mostly stable settings
    // with junk in the unused upper data bits, every third phase fully random.
    task automatic test_random_phases();
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph % 3 == 2)
            begin
                load_gains(31'($urandom), 31'($urandom), 31'($urandom),
                           31'($urandom), 31'($urandom));
            end
            else
            begin
                load_gains({7'($urandom), 24'($urandom_range(32'h1000, 32'h6_0000))},
                           {7'($urandom), 24'($urandom_range(32'h1000, 32'h6_0000))},
                           {14'($urandom), 17'($urandom_range(32'hC000, 32'h1_0000))},
                           {14'($urandom), 17'($urandom_range(32'hC000, 32'h1_0000))},
                           31'($urandom_range(0, 32'h4000)));
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                push_step(random_step());
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_time_edges();
        test_saturation();
        test_dead_band();
        test_unused_index();
        test_random_phases();
        wait_idle();
        // let any stray word show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("asymmetric_damped_spring_follower_top: match");
        end
        else
        begin
            $display("asymmetric_damped_spring_follower_top: mismatch");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (every word a full second,
    // longest sender gap and receiver stall on each).
    initial
    begin
        #100_000_000;
        $display("asymmetric_damped_spring_follower_top: mismatch");
        $finish;
    end

endmodule
